// ----- hw/rtl/enu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECEF / ENU rotation package
// Register indexes, operation codes and the coefficient layout of the
// ECEF-to-ENU rotation matrix.
// ----------------------------------------------------------------------------
package enu_pkg;

  // Width of the sine and cosine registers (signed fixed point).
  localparam int COEF_WIDTH      = 32;
  // Operand slice fed to one hardware multiplier (plus a sign bit).
  localparam int LIMB_WIDTH      = 32;
  localparam int CFG_INDEX_WIDTH = 3;

  // Reset value of the cosine registers: 1.0 in Q1.30.
  localparam logic [COEF_WIDTH-1:0] COEF_RESET_ONE = 32'h4000_0000;
  // Equatorial radius in millimetres, reset value of the origin x register.
  localparam logic [63:0] EARTH_RADIUS_MM = 64'd6378137 * 64'd1000;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SIN_LAT  = 3'd0,
    REG_COS_LAT  = 3'd1,
    REG_SIN_LON  = 3'd2,
    REG_COS_LON  = 3'd3,
    REG_ORIGIN_X = 3'd4,
    REG_ORIGIN_Y = 3'd5,
    REG_ORIGIN_Z = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_ECEF_TO_ENU = 1'b0,
    OP_ENU_TO_ECEF = 1'b1
  } op_e;

  // Sources of one rotation matrix entry.
  typedef enum logic [3:0] {
    CF_ZERO    = 4'd0,
    CF_SIN_LAT = 4'd1,
    CF_COS_LAT = 4'd2,
    CF_SIN_LON = 4'd3,
    CF_COS_LON = 4'd4,
    CF_CLSP    = 4'd5,
    CF_SLSP    = 4'd6,
    CF_CLCP    = 4'd7,
    CF_SLCP    = 4'd8
  } coef_sel_e;

  localparam int NUM_COEF_SEL = 9;

  // Forward matrix, rows east/north/up, columns x/y/z. The inverse uses the
  // transpose. Entries whose bit is set in FWD_NEG are subtracted.
  localparam coef_sel_e FWD_SEL [3][3] = '{
    '{CF_SIN_LON, CF_COS_LON, CF_ZERO},
    '{CF_CLSP,    CF_SLSP,    CF_COS_LAT},
    '{CF_CLCP,    CF_SLCP,    CF_SIN_LAT}
  };
  localparam logic [2:0] FWD_NEG [3] = '{3'b001, 3'b011, 3'b000};

endpackage

// ----- hw/rtl/ecef_enu_rotation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECEF / local East-North-Up rotation
// Converts one 3D point per clock between Earth-centred coordinates and the
// East-North-Up frame of a configurable origin, in a six-stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy: there
// is no loop and no shared unit, so start may stay high indefinitely. Each
// result appears on the out_* ports for one cycle with done_o high, after
// passing the six register stages, and the receiver cannot hold it off. The
// stages are input capture, origin subtraction, 33x33 partial products,
// product assembly, the three-term sum with origin and rounding offset, and
// the rounding shift with saturation into the output register. Results leave
// in input order. The four products of two coefficients (cos_lon*sin_lat and
// so on) are kept in a two-register chain beside the pipeline, so a
// configuration write must pass through that chain before the first item
// that should see it is multiplied; the origin registers are read directly.
// ----------------------------------------------------------------------------
module ecef_enu_rotation import enu_pkg::*; #(
  parameter int COORD_WIDTH    = 40,
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          we_i,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  // Command side
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic signed [COORD_WIDTH-1:0] in_first_i,
  input  logic signed [COORD_WIDTH-1:0] in_second_i,
  input  logic signed [COORD_WIDTH-1:0] in_third_i,
  // Result side
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] out_first_o,
  output logic signed [COORD_WIDTH-1:0] out_second_o,
  output logic signed [COORD_WIDTH-1:0] out_third_o
);

  // Derived coefficients: a product of two Q1.30 values rounded back to
  // COEF_FRAC_BITS fraction bits needs up to 2*32-F bits.
  localparam int PW  = 2 * COEF_WIDTH;
  localparam int KW  = PW - COEF_FRAC_BITS;
  // Forward mode subtracts the origin, which grows the vector by one bit.
  localparam int VW  = COORD_WIDTH + 1;
  localparam int NK  = (KW + LIMB_WIDTH - 1) / LIMB_WIDTH;
  localparam int NV  = (VW + LIMB_WIDTH - 1) / LIMB_WIDTH;
  localparam int PPW = 2 * (LIMB_WIDTH + 1);
  // Three products plus the shifted origin fit with two bits of headroom.
  localparam int AW  = KW + VW + 2;
  localparam int RW  = AW - COEF_FRAC_BITS;

  localparam logic signed [PW-1:0] PROD_HALF =
    {{(PW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] ACC_HALF =
    {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_MAX =
    {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_MIN = ~SAT_MAX;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COEF_WIDTH-1:0]  sin_lat_q, cos_lat_q, sin_lon_q, cos_lon_q;
  logic signed [COORD_WIDTH-1:0] origin_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_lat_q   <= '0;
      cos_lat_q   <= COEF_RESET_ONE;
      sin_lon_q   <= '0;
      cos_lon_q   <= COEF_RESET_ONE;
      origin_q[0] <= COORD_WIDTH'(EARTH_RADIUS_MM);
      origin_q[1] <= '0;
      origin_q[2] <= '0;
    end else if (we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SIN_LAT:  sin_lat_q   <= cfg_data_i[COEF_WIDTH-1:0];
        REG_COS_LAT:  cos_lat_q   <= cfg_data_i[COEF_WIDTH-1:0];
        REG_SIN_LON:  sin_lon_q   <= cfg_data_i[COEF_WIDTH-1:0];
        REG_COS_LON:  cos_lon_q   <= cfg_data_i[COEF_WIDTH-1:0];
        REG_ORIGIN_X: origin_q[0] <= cfg_data_i;
        REG_ORIGIN_Y: origin_q[1] <= cfg_data_i;
        REG_ORIGIN_Z: origin_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Coefficient products: a full product register, then the rounded value.
  // Order is cl*sp, sl*sp, cl*cp, sl*cp.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] dprod_q [4];
  logic signed [KW-1:0] dcoef_q [4];
  logic signed [PW-1:0] dround [4];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      dround[p] = (dprod_q[p] + PROD_HALF) >>> COEF_FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    dprod_q[0] <= cos_lon_q * sin_lat_q;
    dprod_q[1] <= sin_lon_q * sin_lat_q;
    dprod_q[2] <= cos_lon_q * cos_lat_q;
    dprod_q[3] <= sin_lon_q * cos_lat_q;
    for (int p = 0; p < 4; p++) begin
      dcoef_q[p] <= dround[p][KW-1:0];
    end
  end

  logic signed [KW-1:0] coef_all [NUM_COEF_SEL];

  always_comb begin
    coef_all[CF_ZERO]    = '0;
    coef_all[CF_SIN_LAT] = KW'(sin_lat_q);
    coef_all[CF_COS_LAT] = KW'(cos_lat_q);
    coef_all[CF_SIN_LON] = KW'(sin_lon_q);
    coef_all[CF_COS_LON] = KW'(cos_lon_q);
    coef_all[CF_CLSP]    = dcoef_q[0];
    coef_all[CF_SLSP]    = dcoef_q[1];
    coef_all[CF_CLCP]    = dcoef_q[2];
    coef_all[CF_SLCP]    = dcoef_q[3];
  end

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  logic                          a_valid_q, b_valid_q, c_valid_q;
  logic                          d_valid_q, e_valid_q, done_q;
  op_e                           a_op_q, b_op_q, c_op_q, d_op_q;
  logic signed [COORD_WIDTH-1:0] a_vec_q [3];
  logic signed [VW-1:0]          b_vec_q [3];
  logic signed [VW-1:0]          b_vec_d [3];
  logic signed [PPW-1:0]         c_pp_q [3][3][NK][NV];
  logic signed [PPW-1:0]         c_pp_d [3][3][NK][NV];
  logic [2:0]                    c_neg_q [3];
  logic [2:0]                    c_neg_d [3];
  logic [2:0]                    d_neg_q [3];
  logic signed [AW-1:0]          d_prod_q [3][3];
  logic signed [AW-1:0]          d_prod_d [3][3];
  logic signed [AW-1:0]          e_acc_q [3];
  logic signed [AW-1:0]          e_acc_d [3];
  logic signed [COORD_WIDTH-1:0] out_q [3];
  logic signed [COORD_WIDTH-1:0] out_d [3];

  // Valid bits travel with the data; nothing ever stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      a_valid_q <= start & ~busy;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      done_q    <= e_valid_q;
    end
  end

  // Forward mode removes the origin before the rotation.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (a_op_q == OP_ECEF_TO_ENU) begin
        b_vec_d[k] = VW'(a_vec_q[k]) - VW'(origin_q[k]);
      end else begin
        b_vec_d[k] = VW'(a_vec_q[k]);
      end
    end
  end

  // Each matrix entry times its vector element is split into 33x33 signed
  // partial products: low slices are taken as unsigned, the top one signed.
  always_comb begin
    coef_sel_e                     sel;
    logic signed [NK*LIMB_WIDTH-1:0] cx;
    logic signed [NV*LIMB_WIDTH-1:0] vx;
    logic signed [LIMB_WIDTH:0]    la;
    logic signed [LIMB_WIDTH:0]    lb;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (b_op_q == OP_ENU_TO_ECEF) begin
          sel           = FWD_SEL[k][r];
          c_neg_d[r][k] = FWD_NEG[k][r];
        end else begin
          sel           = FWD_SEL[r][k];
          c_neg_d[r][k] = FWD_NEG[r][k];
        end
        cx = (NK*LIMB_WIDTH)'(coef_all[sel]);
        vx = (NV*LIMB_WIDTH)'(b_vec_q[k]);
        for (int i = 0; i < NK; i++) begin
          for (int j = 0; j < NV; j++) begin
            if (i == NK - 1) begin
              la = {cx[NK*LIMB_WIDTH-1], cx[i*LIMB_WIDTH +: LIMB_WIDTH]};
            end else begin
              la = {1'b0, cx[i*LIMB_WIDTH +: LIMB_WIDTH]};
            end
            if (j == NV - 1) begin
              lb = {vx[NV*LIMB_WIDTH-1], vx[j*LIMB_WIDTH +: LIMB_WIDTH]};
            end else begin
              lb = {1'b0, vx[j*LIMB_WIDTH +: LIMB_WIDTH]};
            end
            c_pp_d[r][k][i][j] = la * lb;
          end
        end
      end
    end
  end

  // Reassemble each full product; the sum is exact modulo 2^AW and the
  // true product fits, so dropped upper bits never matter.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        d_prod_d[r][k] = '0;
        for (int i = 0; i < NK; i++) begin
          for (int j = 0; j < NV; j++) begin
            d_prod_d[r][k] = d_prod_d[r][k]
                           + (AW'(c_pp_q[r][k][i][j]) << (LIMB_WIDTH * (i + j)));
          end
        end
      end
    end
  end

  // Three signed terms, the origin in inverse mode, and the rounding offset.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      e_acc_d[r] = ACC_HALF;
      if (d_op_q == OP_ENU_TO_ECEF) begin
        e_acc_d[r] = e_acc_d[r] + (AW'(origin_q[r]) <<< COEF_FRAC_BITS);
      end
      for (int k = 0; k < 3; k++) begin
        if (d_neg_q[r][k]) begin
          e_acc_d[r] = e_acc_d[r] - d_prod_q[r][k];
        end else begin
          e_acc_d[r] = e_acc_d[r] + d_prod_q[r][k];
        end
      end
    end
  end

  // Drop the fraction bits and clamp to the coordinate range.
  always_comb begin
    logic signed [RW-1:0] rw;
    for (int r = 0; r < 3; r++) begin
      rw = e_acc_q[r][AW-1:COEF_FRAC_BITS];
      priority if (rw > SAT_MAX) begin
        out_d[r] = SAT_MAX[COORD_WIDTH-1:0];
      end else if (rw < SAT_MIN) begin
        out_d[r] = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
        out_d[r] = rw[COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_op_q     <= op_e'(operation_i);
    a_vec_q[0] <= in_first_i;
    a_vec_q[1] <= in_second_i;
    a_vec_q[2] <= in_third_i;
    b_op_q     <= a_op_q;
    b_vec_q    <= b_vec_d;
    c_op_q     <= b_op_q;
    c_neg_q    <= c_neg_d;
    c_pp_q     <= c_pp_d;
    d_op_q     <= c_op_q;
    d_neg_q    <= c_neg_q;
    d_prod_q   <= d_prod_d;
    e_acc_q    <= e_acc_d;
    out_q      <= out_d;
  end

  assign busy         = 1'b0;
  assign done_o       = done_q;
  assign out_first_o  = out_q[0];
  assign out_second_o = out_q[1];
  assign out_third_o  = out_q[2];

endmodule

// ----- test/ecef_enu_rotation_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECEF / ENU rotation testbench
// Drives points through the rotation block in both directions under a series
// of origin frames, predicts every converted point with an exact wide-integer
// model of the fixed-point arithmetic, and compares each result field by
// field in arrival order.
// ----------------------------------------------------------------------------
module ecef_enu_rotation_test;
  import enu_pkg::*;

  localparam int COORD_W     = 40;
  localparam int FRAC_BITS   = 30;
  // Six register stages between the accepting edge and the result strobe.
  localparam int LATENCY     = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int FRAME_ITEMS = 250;

  // Register index one past the end of the list. Writes to it must be ignored.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NONE = 3'd7;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Q1.30 coefficient values used by the directed frames.
  localparam logic [COEF_WIDTH-1:0] Q_ONE        = 32'h4000_0000;
  localparam logic [COEF_WIDTH-1:0] Q_MINUS_ONE  = 32'hC000_0000;
  localparam logic [COEF_WIDTH-1:0] Q_HALF       = 32'h2000_0000;
  localparam logic [COEF_WIDTH-1:0] Q_MINUS_HALF = 32'hE000_0000;
  localparam logic [COEF_WIDTH-1:0] Q_LSB        = 32'h0000_0001;

  // Kinds of random frame: in-range coefficients with an Earth-sized origin,
  // the corners of the legal ranges, and unrestricted 32-bit coefficients.
  typedef enum int {
    FRAME_EARTH,
    FRAME_EXTREME,
    FRAME_WILD
  } frame_kind_e;

  localparam frame_kind_e FRAME_PLAN [6] = '{
    FRAME_EARTH, FRAME_EXTREME, FRAME_EARTH, FRAME_WILD, FRAME_EARTH, FRAME_EXTREME
  };

  // Wide enough to hold every product and three-term sum without overflow.
  typedef logic signed [127:0] acc_t;

  typedef struct {
    logic signed [COORD_W-1:0] first;
    logic signed [COORD_W-1:0] second;
    logic signed [COORD_W-1:0] third;
  } point_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          we_i        = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]    cfg_index_i = '0;
  logic [COORD_W-1:0]            cfg_data_i  = '0;
  logic                          start       = 1'b0;
  logic                          busy;
  logic                          operation_i = 1'b0;
  logic signed [COORD_W-1:0]     in_first_i  = '0;
  logic signed [COORD_W-1:0]     in_second_i = '0;
  logic signed [COORD_W-1:0]     in_third_i  = '0;
  logic                          done_o;
  logic signed [COORD_W-1:0]     out_first_o;
  logic signed [COORD_W-1:0]     out_second_o;
  logic signed [COORD_W-1:0]     out_third_o;

  // Our copy of the frame registers, starting from the reset frame: origin on
  // the equator at the prime meridian.
  logic signed [COEF_WIDTH-1:0] frame_sin_lat  = '0;
  logic signed [COEF_WIDTH-1:0] frame_cos_lat  = COEF_RESET_ONE;
  logic signed [COEF_WIDTH-1:0] frame_sin_lon  = '0;
  logic signed [COEF_WIDTH-1:0] frame_cos_lon  = COEF_RESET_ONE;
  logic signed [COORD_W-1:0]    frame_origin_x = EARTH_RADIUS_MM[COORD_W-1:0];
  logic signed [COORD_W-1:0]    frame_origin_y = '0;
  logic signed [COORD_W-1:0]    frame_origin_z = '0;

  // Converted points still in flight, oldest first.
  point_t      pending_points [$];
  int          fault_count = 0;
  int unsigned cycle_count = 0;

  ecef_enu_rotation #(
    .COORD_WIDTH   (COORD_W),
    .COEF_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .in_first_i  (in_first_i),
    .in_second_i (in_second_i),
    .in_third_i  (in_third_i),
    .done_o      (done_o),
    .out_first_o (out_first_o),
    .out_second_o(out_second_o),
    .out_third_o (out_third_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case results stop coming.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Drops the fraction bits, rounding to nearest with ties toward plus
  // infinity: add one half, then shift right arithmetically.
  function automatic acc_t round_frac(acc_t a);
    acc_t half;
    half = 1;
    half = half <<< (FRAC_BITS - 1);
    return (a + half) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [COORD_W-1:0] saturate(acc_t a);
    acc_t top;
    acc_t bottom;
    top    = COORD_MAX;
    bottom = COORD_MIN;
    if (a > top) return COORD_MAX;
    if (a < bottom) return COORD_MIN;
    return a[COORD_W-1:0];
  endfunction

  // Converts one point with the current frame. The forward direction removes
  // the origin and applies the ENU rotation; the inverse applies the
  // transpose and adds the origin, scaled up to the fraction bits, before the
  // final rounding. Products of two coefficients are rounded on their own
  // first, and the sign of a negative matrix entry is applied after that.
  function automatic point_t rotate_point(op_e op, logic signed [COORD_W-1:0] a,
                                          logic signed [COORD_W-1:0] b,
                                          logic signed [COORD_W-1:0] c);
    acc_t   sp, cp, sl, cl;
    acc_t   clsp, slsp, clcp, slcp;
    acc_t   v0, v1, v2, o0, o1, o2, r0, r1, r2;
    point_t p;
    sp = frame_sin_lat;
    cp = frame_cos_lat;
    sl = frame_sin_lon;
    cl = frame_cos_lon;
    o0 = frame_origin_x;
    o1 = frame_origin_y;
    o2 = frame_origin_z;
    v0 = a;
    v1 = b;
    v2 = c;
    clsp = round_frac(cl * sp);
    slsp = round_frac(sl * sp);
    clcp = round_frac(cl * cp);
    slcp = round_frac(sl * cp);
    if (op == OP_ECEF_TO_ENU) begin
      v0 = v0 - o0;
      v1 = v1 - o1;
      v2 = v2 - o2;
      r0 = -sl * v0 + cl * v1;
      r1 = -clsp * v0 - slsp * v1 + cp * v2;
      r2 = clcp * v0 + slcp * v1 + sp * v2;
    end else begin
      r0 = -sl * v0 - clsp * v1 + clcp * v2 + (o0 <<< FRAC_BITS);
      r1 = cl * v0 - slsp * v1 + slcp * v2 + (o1 <<< FRAC_BITS);
      r2 = cp * v1 + sp * v2 + (o2 <<< FRAC_BITS);
    end
    p.first  = saturate(round_frac(r0));
    p.second = saturate(round_frac(r1));
    p.third  = saturate(round_frac(r2));
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Result check: the receiver cannot stall, so every strobe is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    point_t want;
    if (rst_ni && done_o) begin
      if (pending_points.size() == 0) begin
        $error("result with no item outstanding: %0d %0d %0d",
               out_first_o, out_second_o, out_third_o);
        fault_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_first_o !== want.first) begin
          $error("out_first: expected %0d, got %0d", want.first, out_first_o);
          fault_count++;
        end
        if (out_second_o !== want.second) begin
          $error("out_second: expected %0d, got %0d", want.second, out_second_o);
          fault_count++;
        end
        if (out_third_o !== want.third) begin
          $error("out_third: expected %0d, got %0d", want.third, out_third_o);
          fault_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly a point within about 17 km of the given centre; otherwise any
  // 40-bit value, one of the range ends, or a value close to zero.
  function automatic logic signed [COORD_W-1:0] random_coord(
      logic signed [COORD_W-1:0] centre);
    logic signed [24:0] near;
    logic signed [8:0]  tiny;
    logic [63:0]        wide;
    near = 25'($urandom);
    tiny = 9'($urandom);
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return centre + near;
      6, 7:             return wide[COORD_W-1:0];
      8:                return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default:          return COORD_W'(tiny);
    endcase
  endfunction

  function automatic logic [COEF_WIDTH-1:0] random_coef(frame_kind_e kind);
    logic [COEF_WIDTH-1:0] span;
    span = $urandom_range(0, 32'h8000_0000);
    case (kind)
      FRAME_EARTH: return span - Q_ONE;   // anywhere in [-1.0, +1.0]
      FRAME_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return Q_ONE;
          1:       return Q_MINUS_ONE;
          2:       return '0;
          default: return Q_LSB;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] random_origin(frame_kind_e kind);
    logic signed [33:0] earth;
    logic [63:0]        wide;
    earth = 34'({$urandom, $urandom});
    wide  = {$urandom, $urandom};
    case (kind)
      FRAME_EARTH: return COORD_W'(earth);
      FRAME_EXTREME: begin
        case ($urandom_range(0, 2))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          default: return '0;
        endcase
      end
      default: return wide[COORD_W-1:0];
    endcase
  endfunction

  // Presents one item and holds it until the block takes it. start is left
  // high so that a following item can go out on the very next cycle.
  task automatic send_point(op_e op, logic signed [COORD_W-1:0] a,
                            logic signed [COORD_W-1:0] b,
                            logic signed [COORD_W-1:0] c);
    start       <= 1'b1;
    operation_i <= op;
    in_first_i  <= a;
    in_second_i <= b;
    in_third_i  <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_points.push_back(rotate_point(op, a, b, c));
  endtask

  // A gap in the item stream. The payload carries garbage while start is low.
  task automatic idle(int cycles);
    if (cycles > 0) begin
      start       <= 1'b0;
      operation_i <= 1'($urandom);
      in_first_i  <= random_coord('0);
      in_second_i <= random_coord('0);
      in_third_i  <= random_coord('0);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stops sending and lets the pipeline empty before the frame may change.
  task automatic quiesce();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // One register write. The write enable stays up; the caller drops it once
  // the last write has gone out. Our frame copy follows the block's.
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [COORD_W-1:0] data);
    we_i        <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (index)
      REG_SIN_LAT:  frame_sin_lat  = data[COEF_WIDTH-1:0];
      REG_COS_LAT:  frame_cos_lat  = data[COEF_WIDTH-1:0];
      REG_SIN_LON:  frame_sin_lon  = data[COEF_WIDTH-1:0];
      REG_COS_LON:  frame_cos_lon  = data[COEF_WIDTH-1:0];
      REG_ORIGIN_X: frame_origin_x = data;
      REG_ORIGIN_Y: frame_origin_y = data;
      REG_ORIGIN_Z: frame_origin_z = data;
      default: ;  // index past the list, no register behind it
    endcase
  endtask

  // Loads a complete frame. The bits above the 32-bit coefficients carry
  // garbage, which the block must drop, and the unused index is written too.
  // The enable falls before the next item is sent, so the coefficient
  // product registers have settled.
  task automatic load_frame(logic [COEF_WIDTH-1:0] sin_lat, logic [COEF_WIDTH-1:0] cos_lat,
                            logic [COEF_WIDTH-1:0] sin_lon, logic [COEF_WIDTH-1:0] cos_lon,
                            logic [COORD_W-1:0] origin_x, logic [COORD_W-1:0] origin_y,
                            logic [COORD_W-1:0] origin_z);
    logic [COORD_W-COEF_WIDTH-1:0] junk;
    logic [63:0]                   wide;
    junk = (COORD_W-COEF_WIDTH)'($urandom);
    wide = {$urandom, $urandom};
    quiesce();
    write_reg(REG_SIN_LAT, {junk, sin_lat});
    write_reg(REG_COS_LAT, {~junk, cos_lat});
    write_reg(REG_SIN_LON, {junk, sin_lon});
    write_reg(REG_COS_LON, {~junk, cos_lon});
    write_reg(REG_ORIGIN_X, origin_x);
    write_reg(REG_ORIGIN_Y, origin_y);
    write_reg(REG_ORIGIN_Z, origin_z);
    write_reg(REG_NONE, wide[COORD_W-1:0]);
    we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random items in bursts. Forward items mostly lie near the origin and
  // inverse items mostly near the local frame's centre, as real point clouds
  // would; the rest are spread over the whole coordinate range.
  task automatic stream_points(int count);
    int                        sent;
    int                        burst;
    op_e                       op;
    logic signed [COORD_W-1:0] cx, cy, cz;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < count; k++) begin
        op = $urandom_range(0, 1) ? OP_ENU_TO_ECEF : OP_ECEF_TO_ENU;
        cx = (op == OP_ECEF_TO_ENU) ? frame_origin_x : '0;
        cy = (op == OP_ECEF_TO_ENU) ? frame_origin_y : '0;
        cz = (op == OP_ECEF_TO_ENU) ? frame_origin_z : '0;
        send_point(op, random_coord(cx), random_coord(cy), random_coord(cz));
        sent++;
      end
      idle(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The frame left by reset: the origin itself must map to zero and back.
  task automatic test_reset_frame();
    send_point(OP_ECEF_TO_ENU, EARTH_RADIUS_MM[COORD_W-1:0], 0, 0);
    send_point(OP_ECEF_TO_ENU, 0, 1000, -1000);
    send_point(OP_ENU_TO_ECEF, 0, 0, 0);
    send_point(OP_ENU_TO_ECEF, 1000, -2000, 3000);
  endtask

  // Half-valued coefficients put two of the four coefficient products exactly
  // on a tie, which must round toward plus infinity.
  task automatic test_rounding_ties();
    load_frame(Q_LSB, Q_HALF, Q_MINUS_HALF, Q_HALF, '0, '0, '0);
    send_point(OP_ECEF_TO_ENU, 1, -1, 3);
    send_point(OP_ECEF_TO_ENU, -1, 1, -3);
    send_point(OP_ENU_TO_ECEF, 1, 1, 1);
    send_point(OP_ENU_TO_ECEF, -1, -1, -1);
  endtask

  // Coordinates and origins at the range ends drive the results into
  // saturation both ways; the last frame holds coefficients outside
  // [-1.0, +1.0], which are taken as their raw two's complement value.
  task automatic test_extremes();
    load_frame(Q_ONE, Q_ONE, Q_ONE, Q_ONE, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(OP_ECEF_TO_ENU, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(OP_ECEF_TO_ENU, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(OP_ENU_TO_ECEF, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(OP_ENU_TO_ECEF, COORD_MIN, COORD_MIN, COORD_MIN);
    load_frame(Q_MINUS_ONE, Q_MINUS_ONE, Q_MINUS_ONE, Q_MINUS_ONE,
               COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(OP_ECEF_TO_ENU, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(OP_ENU_TO_ECEF, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(OP_ENU_TO_ECEF, COORD_MAX, COORD_MAX, COORD_MAX);
    load_frame(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
               '0, COORD_MAX, COORD_MIN);
    send_point(OP_ECEF_TO_ENU, COORD_MAX, COORD_MIN, 12345);
    send_point(OP_ENU_TO_ECEF, COORD_MIN, COORD_MAX, -1);
  endtask

  // A write to the index past the register list must leave the frame alone.
  task automatic test_unused_index();
    quiesce();
    write_reg(REG_NONE, '1);
    we_i <= 1'b0;
    @(posedge clk_i);
    send_point(OP_ECEF_TO_ENU, frame_origin_x + 40'sd7, frame_origin_y - 40'sd3, 40'sd11);
    send_point(OP_ENU_TO_ECEF, -40'sd5, 40'sd9, 40'sd2);
  endtask

  // Several random frames, each followed by a random item stream.
  task automatic test_random_frames();
    frame_kind_e kind;
    for (int f = 0; f < $size(FRAME_PLAN); f++) begin
      kind = FRAME_PLAN[f];
      load_frame(random_coef(kind), random_coef(kind), random_coef(kind), random_coef(kind),
                 random_origin(kind), random_origin(kind), random_origin(kind));
      stream_points(FRAME_ITEMS);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_frame();
    test_rounding_ties();
    test_extremes();
    test_unused_index();
    test_random_frames();

    // Let every outstanding point come back, then a few more cycles in case
    // the block produces something nobody asked for.
    quiesce();
    if (fault_count == 0 && pending_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/enu_pkg.sv
hw/rtl/ecef_enu_rotation.sv
test/ecef_enu_rotation_test.sv
